@@ src/cut_timestamp_rebaser_top_macros.svh @@
// Assertion macros shared by the timestamp rebaser modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CUT_TIMESTAMP_REBASER_TOP_MACROS_SVH
`define CUT_TIMESTAMP_REBASER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define CTR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CTR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CTR_ASSERT_IMP(lbl, ante, cons, msg)
`define CTR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/ctr_pkg.sv @@
// Types and constants for the cut recording timestamp rebaser.
// No dependencies; the interfaces and the decide, format and top modules import it.
`timescale 1ns / 1ps

package ctr_pkg;

	localparam int MAX_STREAMS_DEF = 16;

	localparam int SID_W   = 8;
	localparam int CNT_W   = 5;
	localparam int IN_TS_W = 40;
	localparam int TS_W    = 48;
	localparam int SPAN_W  = 24;
	localparam int FRAME_W = 31;
	localparam int ACT_W   = 2;

	localparam logic [CNT_W-1:0] STREAM_COUNT_RST = CNT_W'(16);

	// decode time rollover of the 33-bit transport clock
	localparam int              WRAP_BIT  = 33;
	localparam logic [TS_W-1:0] WRAP_STEP = TS_W'(64'h2_0000_0000);

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE  = 2'd0,
		ACT_DROP   = 2'd1,
		ACT_IGNORE = 2'd2,
		ACT_ERROR  = 2'd3
	} action_t;

	// one entry of the per-stream table
	typedef struct packed {
		logic [TS_W-1:0] last_decode;
		logic [TS_W-1:0] wrap;
	} tbl_entry_t;

	// decision handed from the decide stage to the output stage
	typedef struct packed {
		action_t            action;
		logic [IN_TS_W-1:0] pts;
		logic [IN_TS_W-1:0] dts;
		logic [TS_W-1:0]    wrap;
		logic [TS_W-1:0]    cut;
	} dec_t;

endpackage

@@ src/ctr_in_if.sv @@
// Packet descriptor channel: valid/ready handshake plus descriptor fields.
// Depends on ctr_pkg.
`timescale 1ns / 1ps

interface ctr_in_if import ctr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SID_W-1:0]   stream_id;
	logic               has_dts;
	logic [IN_TS_W-1:0] decode_time;
	logic [IN_TS_W-1:0] present_time;
	logic [SPAN_W-1:0]  span;
	logic [FRAME_W-1:0] frame_no;
	logic               is_video;

	modport source (
		output valid, stream_id, has_dts, decode_time, present_time, span, frame_no,
			is_video,
		input  ready
	);
	modport sink (
		input  valid, stream_id, has_dts, decode_time, present_time, span, frame_no,
			is_video,
		output ready
	);
endinterface

@@ src/ctr_out_if.sv @@
// Result channel: valid/ready handshake plus action and rebased timestamps.
// Depends on ctr_pkg.
`timescale 1ns / 1ps

interface ctr_out_if import ctr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [ACT_W-1:0]       action;
	logic signed [TS_W-1:0] new_present_time;
	logic signed [TS_W-1:0] new_decode_time;

	modport source (
		output valid, action, new_present_time, new_decode_time,
		input  ready
	);
	modport sink (
		input  valid, action, new_present_time, new_decode_time,
		output ready
	);
endinterface

@@ src/ctr_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// Depends on ctr_pkg only by convention; no types used.
`timescale 1ns / 1ps

module ctr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/ctr_decide.sv @@
// Decide stage: input register, per-stream table, cut and wrap bookkeeping.
// Depends on ctr_pkg, ctr_in_if, ctr_ram and the assertion macros.
`timescale 1ns / 1ps
`include "cut_timestamp_rebaser_top_macros.svh"

module ctr_decide import ctr_pkg::*; #(
	parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] stream_count,
	ctr_in_if.sink           pkt,
	output logic             dec_valid,
	input  logic             dec_ready,
	output dec_t             dec
);

	localparam int IDX_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam logic [SID_W-1:0] MAX_SID = SID_W'(MAX_STREAMS);

	// stage 1: accepted descriptor
	logic               s1_valid;
	logic [SID_W-1:0]   sid_s1;
	logic               has_dts_s1;
	logic [IN_TS_W-1:0] dts_s1;
	logic [IN_TS_W-1:0] pts_s1;
	logic [SPAN_W-1:0]  span_s1;
	logic [FRAME_W-1:0] frame_s1;
	logic               video_s1;
	logic               fwd_s1;
	tbl_entry_t         fwd_data_s1;

	// stage 2: decision
	logic s2_valid;
	dec_t dec_s2;

	// global state
	logic [TS_W-1:0]        cut_q;
	logic [TS_W-1:0]        start_q;
	logic [FRAME_W-1:0]     last_frame_q;
	logic [MAX_STREAMS-1:0] vld_q;

	logic               pkt_acc;
	logic               s1_adv;
	logic               upd;
	logic [SID_W-1:0]   cnt_ext;
	logic [SID_W-1:0]   limit;
	logic [IDX_W-1:0]   idx_s1;
	logic [IDX_W-1:0]   pkt_idx;
	tbl_entry_t         ram_rd;
	tbl_entry_t         entry;
	tbl_entry_t         wr_data;
	logic               wr_en;
	logic [TS_W-1:0]    ld;
	logic [TS_W-1:0]    wo;
	logic [TS_W-1:0]    wo2;
	logic [TS_W-1:0]    dts48;
	logic [TS_W-1:0]    pts48;
	logic [TS_W-1:0]    span48;
	logic [TS_W-1:0]    cut2;
	logic [FRAME_W:0]   lf_inc;
	logic               ignore;
	logic               err;
	logic               not_inc;
	logic               wrap_ok;
	logic               drop_wrap;
	logic               newcut;
	logic               early;
	logic               pass;
	action_t            act;

	assign pkt_acc = pkt.valid && pkt.ready;
	assign s1_adv  = s1_valid && (!s2_valid || dec_ready);
	assign pkt.ready = !s1_valid || s1_adv;
	assign pkt_idx = pkt.stream_id[IDX_W-1:0];
	assign idx_s1  = sid_s1[IDX_W-1:0];

	ctr_ram #(
		.WIDTH($bits(tbl_entry_t)),
		.DEPTH(MAX_STREAMS)
	) u_tbl (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_s1),
		.wr_data (wr_data),
		.rd_en   (pkt_acc),
		.rd_addr (pkt_idx),
		.rd_data (ram_rd)
	);

	always_comb begin
		cnt_ext = SID_W'(stream_count);
		limit   = (cnt_ext < MAX_SID) ? cnt_ext : MAX_SID;

		// take the entry written at the accepting edge, else the valid table entry, else zero
		if (fwd_s1) begin
			entry = fwd_data_s1;
		end else if (vld_q[idx_s1]) begin
			entry = ram_rd;
		end else begin
			entry = '0;
		end
		ld = entry.last_decode;
		wo = entry.wrap;

		dts48  = TS_W'(dts_s1);
		pts48  = TS_W'(pts_s1);
		span48 = TS_W'(span_s1);

		ignore    = sid_s1 >= limit;
		err       = !has_dts_s1 || (pts_s1 < dts_s1);
		not_inc   = !($signed(ld) < $signed(dts48));
		wrap_ok   = !ld[WRAP_BIT] && dts48[WRAP_BIT];
		drop_wrap = not_inc && !wrap_ok;
		wo2       = not_inc ? wo + WRAP_STEP : wo;

		lf_inc = {1'b0, last_frame_q} + (FRAME_W+1)'(1);
		newcut = video_s1 && ({1'b0, frame_s1} > lf_inc);
		// an empty table entry makes the cut step zero
		if (newcut && (ld != '0)) begin
			cut2 = cut_q + dts48 - ld - span48;
		end else begin
			cut2 = cut_q;
		end
		early = !newcut && ($signed(pts48) < $signed(start_q));

		pass = !ignore && !err && !drop_wrap;

		priority if (ignore) begin
			act = ACT_IGNORE;
		end else if (err) begin
			act = ACT_ERROR;
		end else if (drop_wrap || early) begin
			act = ACT_DROP;
		end else begin
			act = ACT_WRITE;
		end

		upd     = s1_adv && pass;
		wr_en   = upd;
		wr_data = '{last_decode: dts48 - wo2, wrap: wo2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pkt_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_adv) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			sid_s1      <= pkt.stream_id;
			has_dts_s1  <= pkt.has_dts;
			dts_s1      <= pkt.decode_time;
			pts_s1      <= pkt.present_time;
			span_s1     <= pkt.span;
			frame_s1    <= pkt.frame_no;
			video_s1    <= pkt.is_video;
			fwd_s1      <= wr_en && (idx_s1 == pkt_idx);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cut_q        <= '0;
			start_q      <= '0;
			last_frame_q <= '0;
			vld_q        <= '0;
		end else if (upd) begin
			last_frame_q  <= frame_s1;
			vld_q[idx_s1] <= 1'b1;
			if (newcut) begin
				cut_q   <= cut2;
				start_q <= pts48;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s1_adv) begin
			s2_valid <= 1'b1;
		end else if (dec_ready) begin
			s2_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			dec_s2 <= '{action: act, pts: pts_s1, dts: dts_s1, wrap: wo2, cut: cut2};
		end
	end

	assign dec_valid = s2_valid;
	assign dec       = dec_s2;

	`CTR_ASSERT_IMP(a_no_wr_reject, s1_valid && (ignore || err), !wr_en, "rejected item wrote table")
	`CTR_ASSERT_NXT(a_vld_set, wr_en, vld_q[$past(idx_s1)], "table write left entry invalid")
	`CTR_ASSERT_NXT(a_cut_hold, !(upd && newcut), $stable(cut_q) && $stable(start_q), "cut moved")
	`CTR_ASSERT_NXT(a_fwd_src, pkt_acc && !wr_en, !fwd_s1, "bypass set without a table write")

endmodule

@@ src/ctr_format.sv @@
// Output stage: applies cut and wrap offsets to write results, zeroes the times of
// other actions and holds the result register. Depends on ctr_pkg, ctr_out_if and the assertion macros.
`timescale 1ns / 1ps
`include "cut_timestamp_rebaser_top_macros.svh"

module ctr_format import ctr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic dec_valid,
	output logic dec_ready,
	input  dec_t dec,
	ctr_out_if.source res
);

	logic            out_valid_q;
	action_t         action_q;
	logic [TS_W-1:0] pts_q;
	logic [TS_W-1:0] dts_q;
	logic [TS_W-1:0] pts_new;
	logic [TS_W-1:0] dts_new;
	logic            dec_xfer;

	assign dec_ready = !out_valid_q || res.ready;
	assign dec_xfer  = dec_valid && dec_ready;

	always_comb begin
		if (dec.action == ACT_WRITE) begin
			pts_new = TS_W'(dec.pts) - dec.cut + dec.wrap;
			dts_new = TS_W'(dec.dts) - dec.cut + dec.wrap;
		end else begin
			pts_new = '0;
			dts_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_xfer) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_xfer) begin
			action_q <= dec.action;
			pts_q    <= pts_new;
			dts_q    <= dts_new;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.action           = action_q;
	assign res.new_present_time = $signed(pts_q);
	assign res.new_decode_time  = $signed(dts_q);

	`CTR_ASSERT_NXT(a_out_load, dec_xfer, out_valid_q, "transfer into result register lost")
	`CTR_ASSERT_IMP(a_zero_times, out_valid_q && (action_q != ACT_WRITE), (pts_q == '0) && (dts_q == '0), "non-write result carries times")
	`CTR_ASSERT_NXT(a_res_hold, out_valid_q && !res.ready, out_valid_q && $stable(action_q) && $stable(pts_q) && $stable(dts_q), "waiting result changed")

endmodule

@@ src/cut_timestamp_rebaser_top.sv @@
// Cut recording timestamp rebaser: top level with the stream count register.
// Depends on ctr_pkg, ctr_in_if, ctr_out_if, ctr_decide and ctr_format.
`timescale 1ns / 1ps

// One result per packet descriptor, one descriptor per cycle sustained while
// the receiver takes results: the per-stream table is a RAM read at the
// accepting edge and written when the item leaves the input register, with
// a bypass for back-to-back hits on the same stream. An item passes three
// registers in order (input, decision, result). The input stalls only while
// the receiver holds off and every stage behind the result register is full.
// The stream count register resets to 16 and should only be written while no
// item is in flight.
module cut_timestamp_rebaser_top import ctr_pkg::*; #(
	parameter int MAX_STREAMS = MAX_STREAMS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CNT_W-1:0] cfg_wr_data,
	ctr_in_if.sink           pkt,
	ctr_out_if.source        res
);

	logic [CNT_W-1:0] stream_count_q;
	logic             dec_valid;
	logic             dec_ready;
	dec_t             dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_count_q <= STREAM_COUNT_RST;
		end else if (cfg_wr_en) begin
			stream_count_q <= cfg_wr_data;
		end
	end

	ctr_decide #(
		.MAX_STREAMS(MAX_STREAMS)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.stream_count (stream_count_q),
		.pkt          (pkt),
		.dec_valid    (dec_valid),
		.dec_ready    (dec_ready),
		.dec          (dec)
	);

	ctr_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec),
		.res       (res)
	);

endmodule
